/* src/display_ctrl_register_block_core_assert.svh */
// Assertion macros shared by the display controller register block modules.
`ifndef DISPLAY_CTRL_REGISTER_BLOCK_CORE_ASSERT_SVH
`define DISPLAY_CTRL_REGISTER_BLOCK_CORE_ASSERT_SVH
`ifndef SYNTH
// check a property on every clock edge outside reset
`define DCRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition never holds outside reset
`define DCRB_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DCRB_ASSERT(lbl, prop, msg)
`define DCRB_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* src/dcrb_pkg.sv */
// Types, constants and address helpers for the display controller register block.
`default_nettype none
package dcrb_pkg;

    localparam int REG_WORDS = 268;
    localparam int IDX_W     = $clog2(REG_WORDS);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;
    localparam int KIND_W      = 2;

    localparam logic [15:0] BASE_ADDR  = 16'h1240;
    localparam logic [15:0] CFG0_ADDR  = 16'h1240;
    localparam logic [15:0] CFG1_ADDR  = 16'h1250;
    localparam logic [15:0] INT_ADDR   = 16'h1570;
    localparam logic [15:0] INOUT_ADDR = 16'h1650;
    localparam logic [15:0] CONF_ADDR  = 16'h1660;
    localparam logic [15:0] GPIO_SPAN  = 16'h0007;
    localparam logic [15:0] SPAN_BYTES = 16'(4 * REG_WORDS);

    localparam logic [IDX_W-1:0] INT_IDX   = IDX_W'((INT_ADDR - BASE_ADDR) >> 2);
    localparam logic [IDX_W-1:0] INOUT_IDX = IDX_W'((INOUT_ADDR - BASE_ADDR) >> 2);
    localparam logic [IDX_W-1:0] CONF_IDX  = IDX_W'((CONF_ADDR - BASE_ADDR) >> 2);

    localparam logic [31:0] CFG_CLR_MASK  = 32'h0000_0880;
    localparam logic [31:0] INT_HI_MASK   = 32'hffff_0000;
    localparam logic [31:0] GPIO_RST_WORD = 32'h0000_000f;
    localparam logic [3:0]  GPIO_RST      = 4'hf;
    localparam logic [6:0]  VS_HEAD1      = 7'h01;
    localparam logic [6:0]  VS_HEAD0      = 7'h04;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_GPIO  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] address;
        logic [31:0] write_data;
        logic        head;
        logic [1:0]  gpio_line;
        logic        gpio_level;
    } item_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } mem_wr_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [3:0]  gpio_drive;
    } res_t;

    function automatic logic in_range(input logic [15:0] a);
        return (a >= BASE_ADDR) && ((a - BASE_ADDR) < SPAN_BYTES);
    endfunction

    function automatic logic [IDX_W-1:0] word_index(input logic [15:0] a);
        logic [15:0] off;
        off = a - BASE_ADDR;
        return off[IDX_W+1:2];
    endfunction

endpackage
`default_nettype wire

/* src/dcrb_mem.sv */
// Register file word memory: one write port, one registered read port.
`default_nettype none
module dcrb_mem (
    input  logic                      clk,
    input  dcrb_pkg::mem_req_t        req,
    output logic [31:0]               rdata
);
    import dcrb_pkg::*;

    logic [31:0] mem [REG_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* src/dcrb_exec.sv */
// Item execution: decode, side registers (heads, irq, gpio) and write-back word.
`default_nettype none
`include "display_ctrl_register_block_core_assert.svh"
module dcrb_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  dcrb_pkg::item_t      item,
    input  logic [31:0]          rdata,
    output dcrb_pkg::mem_wr_t    wr,
    output dcrb_pkg::res_t       res
);
    import dcrb_pkg::*;

    logic [1:0]  buf_idx_reg,  buf_idx_next;
    logic [1:0]  enable_reg,   enable_next;
    logic [6:0]  status_reg,   status_next;
    logic [6:0]  mask_reg,     mask_next;
    logic        irq_reg,      irq_next;
    logic [3:0]  in_lvl_reg,   in_lvl_next;
    logic [3:0]  gpio_drv_reg, gpio_drv_next;
    logic [3:0]  old_conf_reg, old_conf_next;
    logic [31:0] conf_reg,     conf_next;
    logic [3:0]  inout_reg,    inout_next;

    logic             in_rng;
    logic [IDX_W-1:0] idx;
    logic             h;
    logic             is_int;
    logic             is_cfg;
    logic             inout_rng;
    logic             conf_rng;
    logic             bi_flip;
    logic [31:0]      gpio_word;
    logic [31:0]      rd;

    always_comb
    begin
        buf_idx_next  = buf_idx_reg;
        enable_next   = enable_reg;
        status_next   = status_reg;
        mask_next     = mask_reg;
        irq_next      = irq_reg;
        in_lvl_next   = in_lvl_reg;
        gpio_drv_next = gpio_drv_reg;
        old_conf_next = old_conf_reg;
        conf_next     = conf_reg;
        inout_next    = inout_reg;

        in_rng    = in_range(item.address);
        idx       = word_index(item.address);
        h         = item.address[4];
        is_int    = (item.address == INT_ADDR);
        is_cfg    = (item.address == CFG0_ADDR) || (item.address == CFG1_ADDR);
        inout_rng = (item.address >= INOUT_ADDR) && (item.address <= INOUT_ADDR + GPIO_SPAN);
        conf_rng  = (item.address >= CONF_ADDR) && (item.address <= CONF_ADDR + GPIO_SPAN);
        bi_flip   = buf_idx_reg[h] ^ item.write_data[7];
        gpio_word = (conf_reg & {28'b0, in_lvl_reg}) | (~conf_reg & rdata);

        wr.we   = 1'b0;
        wr.addr = idx;
        wr.data = item.write_data;
        rd      = '0;

        unique case (item.kind)
            KIND_READ:
            begin
                if (in_rng)
                begin
                    if (is_int)
                    begin
                        rd = (rdata & INT_HI_MASK) | {25'b0, status_reg};
                    end
                    else if (item.address == INOUT_ADDR)
                    begin
                        rd            = gpio_word;
                        gpio_drv_next = gpio_word[3:0];
                    end
                    else
                    begin
                        rd = rdata;
                    end
                end
            end
            KIND_WRITE:
            begin
                wr.we = in_rng;
                // keep shadows of the words the side logic looks at
                if (in_rng && idx == INT_IDX)
                begin
                    mask_next = item.write_data[22:16];
                end
                if (in_rng && idx == INOUT_IDX)
                begin
                    inout_next = item.write_data[3:0];
                end
                if (in_rng && idx == CONF_IDX)
                begin
                    conf_next = item.write_data;
                end

                if (is_int)
                begin
                    status_next = '0;
                    irq_next    = 1'b0;
                end
                else if (is_cfg)
                begin
                    enable_next[h]  = item.write_data[8];
                    buf_idx_next[h] = bi_flip;
                    wr.data = (item.write_data & ~CFG_CLR_MASK) | {20'b0, bi_flip, 11'b0};
                end
                else if (inout_rng)
                begin
                    gpio_drv_next = (conf_next[3:0] & in_lvl_reg) | (~conf_next[3:0] & inout_next);
                end
                else if (conf_rng)
                begin
                    // latch input bits whose line just turned to input
                    in_lvl_next   = in_lvl_reg
                                  | ((old_conf_reg ^ conf_next[3:0]) & conf_next[3:0]);
                    old_conf_next = conf_next[3:0];
                    gpio_drv_next = (conf_next[3:0] & in_lvl_next)
                                  | (~conf_next[3:0] & inout_next);
                end
            end
            KIND_FRAME:
            begin
                if (enable_reg[item.head])
                begin
                    status_next = status_reg | (item.head ? VS_HEAD1 : VS_HEAD0);
                    irq_next    = |(mask_reg & status_next);
                end
            end
            KIND_GPIO:
            begin
                in_lvl_next[item.gpio_line] = item.gpio_level;
            end
            default:
            begin
            end
        endcase

        res.read_data  = rd;
        res.irq        = irq_next;
        res.gpio_drive = gpio_drv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_idx_reg  <= '0;
            enable_reg   <= '0;
            status_reg   <= '0;
            mask_reg     <= '0;
            irq_reg      <= 1'b0;
            in_lvl_reg   <= GPIO_RST;
            gpio_drv_reg <= GPIO_RST;
            old_conf_reg <= '0;
            conf_reg     <= GPIO_RST_WORD;
            inout_reg    <= GPIO_RST;
        end
        else if (commit)
        begin
            buf_idx_reg  <= buf_idx_next;
            enable_reg   <= enable_next;
            status_reg   <= status_next;
            mask_reg     <= mask_next;
            irq_reg      <= irq_next;
            in_lvl_reg   <= in_lvl_next;
            gpio_drv_reg <= gpio_drv_next;
            old_conf_reg <= old_conf_next;
            conf_reg     <= conf_next;
            inout_reg    <= inout_next;
        end
    end

    `DCRB_ASSERT(a_irq_needs_status, (status_reg == 7'd0) |-> !irq_reg, "irq high with no status")
    `DCRB_ASSERT(a_int_write_clears, commit && item.kind == KIND_WRITE && is_int |=> !irq_reg && status_reg == 7'd0, "interrupt write did not clear")
    `DCRB_ASSERT(a_conf_tracks, commit && item.kind == KIND_WRITE && conf_rng |=> old_conf_reg == conf_reg[3:0], "old conf out of step")

endmodule
`default_nettype wire

/* src/display_ctrl_register_block_core.sv */
// Top level of the display controller register block: handshakes, clearing pass, staging.
//
// The cycle an item is accepted issues the read of its word from the register file memory;
// the item then sits in the working stage, which, once the output register is free or being
// taken, applies the update, writes the word back and loads the result into the output
// register. A new item is accepted as soon as the previous one has left the working stage,
// even while its result still waits on the output side, but not before. After reset the
// block sweeps the register file to its reset contents, one word a cycle, through all
// REG_WORDS (268) words with s_axis_tready low.
`default_nettype none
`include "display_ctrl_register_block_core_assert.svh"
module display_ctrl_register_block_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // address[15:0], write_data[47:16], head[48], gpio_line[50:49], gpio_level[51], zero[55:52]
    input  logic [dcrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [dcrb_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[31:0], irq[32], gpio_drive[36:33], zero[39:37]
    output logic [dcrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import dcrb_pkg::*;

    logic             accept;
    logic             commit;
    item_t            in_item;
    item_t            st_item_reg;
    logic             st_valid_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             clr_done_reg;
    mem_req_t         mem_req;
    mem_wr_t          ex_wr;
    res_t             ex_res;
    logic [31:0]      mem_rdata;

    assign in_item.kind       = kind_t'(s_axis_tuser);
    assign in_item.address    = s_axis_tdata[15:0];
    assign in_item.write_data = s_axis_tdata[47:16];
    assign in_item.head       = s_axis_tdata[48];
    assign in_item.gpio_line  = s_axis_tdata[50:49];
    assign in_item.gpio_level = s_axis_tdata[51];

    assign s_axis_tready = clr_done_reg && !st_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = st_valid_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (!clr_done_reg)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_cnt_reg;
            mem_req.wdata = ((clr_cnt_reg == INOUT_IDX) || (clr_cnt_reg == CONF_IDX))
                          ? GPIO_RST_WORD : '0;
        end
        else
        begin
            mem_req.we    = commit && ex_wr.we;
            mem_req.waddr = ex_wr.addr;
            mem_req.wdata = ex_wr.data;
        end
        mem_req.re    = accept && in_range(in_item.address);
        mem_req.raddr = word_index(in_item.address);
    end

    dcrb_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    dcrb_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (st_item_reg),
        .rdata  (mem_rdata),
        .wr     (ex_wr),
        .res    (ex_res)
    );

    // sweep the register file to its reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(REG_WORDS - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                st_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_item_reg <= in_item;
        end
        if (commit)
        begin
            out_res_reg <= ex_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b0, out_res_reg.gpio_drive, out_res_reg.irq, out_res_reg.read_data};

    `DCRB_ASSERT(a_idle_during_clear, !clr_done_reg |-> !st_valid_reg && !out_valid_reg, "item in flight during clearing pass")
    `DCRB_ASSERT(a_commit_moves, commit |=> out_valid_reg && !st_valid_reg, "committed item not moved to output")
    `DCRB_ASSERT(a_stall_holds_stage, st_valid_reg && out_valid_reg && !m_axis_tready |=> st_valid_reg, "staged item dropped under stall")

endmodule
`default_nettype wire

/* tb/tb_display_ctrl_register_block_core.sv */
// Self-checking testbench for the display controller register block: shadow registers predict each response.
`timescale 1ns / 1ps
module tb_display_ctrl_register_block_core;
    import dcrb_pkg::*;

    localparam int HANG_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int BURST_ITEMS  = 250;
    localparam int END_PAUSE    = 8;
    localparam int SPAN_END     = int'(BASE_ADDR) + 4 * REG_WORDS;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    display_ctrl_register_block_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the block state
    logic [31:0] shadow_regs [REG_WORDS];
    bit          shadow_buf [2];
    bit          shadow_en [2];
    logic [6:0]  shadow_status;
    logic [3:0]  shadow_gpio_in;
    logic [31:0] shadow_gpio_drive;
    logic [31:0] shadow_old_conf;
    logic        shadow_irq;

    res_t awaited_resp [$];
    int   fail_count;
    int   rx_stall;
    int   quiet_cycles;
    bit   no_idle;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit in_window(input logic [15:0] a);
        return int'(a) >= int'(BASE_ADDR) && int'(a) < SPAN_END;
    endfunction

    function automatic int word_of(input logic [15:0] a);
        return (int'(a) - int'(BASE_ADDR)) >> 2;
    endfunction

    function automatic void refresh_gpio();
        logic [31:0] conf;
        conf = shadow_regs[word_of(CONF_ADDR)];
        shadow_gpio_drive = (conf & {28'b0, shadow_gpio_in})
                          | (~conf & shadow_regs[word_of(INOUT_ADDR)]);
    endfunction

    function automatic void refresh_irq();
        logic [31:0] mask_word;
        mask_word  = shadow_regs[word_of(INT_ADDR)];
        shadow_irq = |(mask_word[31:16] & {9'b0, shadow_status});
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_regs[word_of(INOUT_ADDR)] = GPIO_RST_WORD;
        shadow_regs[word_of(CONF_ADDR)]  = GPIO_RST_WORD;
        shadow_buf        = '{0, 0};
        shadow_en         = '{0, 0};
        shadow_status     = '0;
        shadow_gpio_in    = GPIO_RST;
        shadow_gpio_drive = GPIO_RST_WORD;
        shadow_old_conf   = '0;
        shadow_irq        = 1'b0;
    endfunction

    function automatic void shadow_write(input logic [15:0] a, input logic [31:0] d);
        int          h;
        logic [31:0] conf;
        h = a[4];
        if (in_window(a))
            shadow_regs[word_of(a)] = d;
        if (a == INT_ADDR) begin
            shadow_status = '0;
            refresh_irq();
        end else if (a == CFG0_ADDR || a == CFG1_ADDR) begin
            shadow_en[h] = d[8];
            if (d[7])
                shadow_buf[h] = ~shadow_buf[h];
            shadow_regs[word_of(a)] = (d & ~CFG_CLR_MASK) | (32'(shadow_buf[h]) << 11);
        end else if (a >= INOUT_ADDR && a <= INOUT_ADDR + GPIO_SPAN) begin
            refresh_gpio();
        end else if (a >= CONF_ADDR && a <= CONF_ADDR + GPIO_SPAN) begin
            conf = shadow_regs[word_of(CONF_ADDR)];
            // latch input bits that just turned to inputs
            shadow_gpio_in  = shadow_gpio_in | ((shadow_old_conf[3:0] ^ conf[3:0]) & conf[3:0]);
            shadow_old_conf = conf;
            refresh_gpio();
        end
    endfunction

    function automatic logic [31:0] shadow_read(input logic [15:0] a);
        if (!in_window(a))
            return '0;
        if (a == INT_ADDR)
            return (shadow_regs[word_of(a)] & INT_HI_MASK) | {25'b0, shadow_status};
        if (a == INOUT_ADDR) begin
            refresh_gpio();
            return shadow_gpio_drive;
        end
        return shadow_regs[word_of(a)];
    endfunction

    // apply one item to the shadow state and return the response it yields
    function automatic res_t serve_item(input item_t it);
        res_t r;
        r.read_data = '0;
        case (it.kind)
            KIND_READ:  r.read_data = shadow_read(it.address);
            KIND_WRITE: shadow_write(it.address, it.write_data);
            KIND_FRAME: begin
                if (shadow_en[it.head]) begin
                    shadow_status = shadow_status | (it.head ? VS_HEAD1 : VS_HEAD0);
                    refresh_irq();
                end
            end
            default:    shadow_gpio_in[it.gpio_line] = it.gpio_level;
        endcase
        r.irq        = shadow_irq;
        r.gpio_drive = shadow_gpio_drive[3:0];
        return r;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.kind       = kind_t'($urandom_range(0, 3));
        it.address    = 16'($urandom);
        it.write_data = $urandom;
        it.head       = 1'($urandom);
        it.gpio_line  = 2'($urandom);
        it.gpio_level = 1'($urandom);
        return it;
    endfunction

    function automatic item_t access_item(input kind_t k, input logic [15:0] a,
                                          input logic [31:0] d);
        item_t it;
        it            = random_item();
        it.kind       = k;
        it.address    = a;
        it.write_data = d;
        return it;
    endfunction

    function automatic item_t frame_item(input logic h);
        item_t it;
        it      = random_item();
        it.kind = KIND_FRAME;
        it.head = h;
        return it;
    endfunction

    function automatic item_t gpio_item(input logic [1:0] line, input logic level);
        item_t it;
        it            = random_item();
        it.kind       = KIND_GPIO;
        it.gpio_line  = line;
        it.gpio_level = level;
        return it;
    endfunction

    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? CFG1_ADDR : CFG0_ADDR;
            1:       return INT_ADDR + 16'($urandom_range(0, 3));
            2:       return INOUT_ADDR + 16'($urandom_range(0, 7));
            3:       return CONF_ADDR + 16'($urandom_range(0, 7));
            4, 5:    return BASE_ADDR + 16'(4 * $urandom_range(0, REG_WORDS - 1));
            6:       return 16'($urandom_range(int'(BASE_ADDR), SPAN_END - 1));
            7:       return $urandom_range(0, 1) ? BASE_ADDR - 16'($urandom_range(0, 4))
                                                 : 16'(SPAN_END - 4 + $urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t pick_item();
        item_t it;
        int    roll;
        it   = random_item();
        roll = $urandom_range(0, 9);
        if (roll <= 2) begin
            it.kind    = KIND_READ;
            it.address = pick_address();
        end else if (roll <= 5) begin
            it.kind    = KIND_WRITE;
            it.address = pick_address();
        end else if (roll <= 7) begin
            it.kind = KIND_FRAME;
        end else if (roll == 8) begin
            it.kind = KIND_GPIO;
        end
        return it;
    endfunction

    // drive one item and hold it until the block takes it
    task automatic send_item(input item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {4'b0, it.gpio_level, it.gpio_line, it.head, it.write_data, it.address};
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_resp.push_back(serve_item(it));
    endtask

    task automatic test_reset_values();
        send_item(access_item(KIND_READ, INT_ADDR, '0));
        send_item(access_item(KIND_READ, INOUT_ADDR, '0));
        send_item(access_item(KIND_READ, CONF_ADDR, '0));
        send_item(access_item(KIND_READ, BASE_ADDR - 16'd1, '0));
        send_item(access_item(KIND_READ, 16'(SPAN_END), '0));
        send_item(access_item(KIND_READ, 16'hffff, '0));
        send_item(access_item(KIND_READ, 16'(SPAN_END - 4), '0));
    endtask

    task automatic test_head_config();
        send_item(access_item(KIND_WRITE, CFG0_ADDR, 32'hffff_ffff));
        send_item(access_item(KIND_READ, CFG0_ADDR, '0));
        send_item(access_item(KIND_WRITE, CFG1_ADDR, 32'h0000_0180));
        // toggle the buffer back and disable head 0
        send_item(access_item(KIND_WRITE, CFG0_ADDR, 32'h0000_0080));
        send_item(frame_item(1'b0));
        send_item(access_item(KIND_WRITE, CFG0_ADDR, 32'h0000_0100));
    endtask

    task automatic test_vsync_irq();
        send_item(access_item(KIND_WRITE, INT_ADDR, 32'h0005_0000));
        send_item(frame_item(1'b0));
        send_item(frame_item(1'b1));
        send_item(access_item(KIND_READ, INT_ADDR, '0));
        // unaligned write keeps status and the latched line
        send_item(access_item(KIND_WRITE, INT_ADDR + 16'd1, 32'h1234_5678));
        send_item(access_item(KIND_READ, INT_ADDR, '0));
        send_item(access_item(KIND_WRITE, INT_ADDR, 32'hffff_0000));
        send_item(frame_item(1'b1));
    endtask

    task automatic test_gpio();
        send_item(gpio_item(2'd0, 1'b0));
        send_item(gpio_item(2'd3, 1'b0));
        send_item(access_item(KIND_READ, INOUT_ADDR, '0));
        send_item(access_item(KIND_WRITE, CONF_ADDR, 32'h0000_0000));
        send_item(access_item(KIND_WRITE, INOUT_ADDR, 32'hffff_fffa));
        send_item(access_item(KIND_WRITE, CONF_ADDR, 32'h0000_0005));
        send_item(access_item(KIND_READ, INOUT_ADDR, '0));
        send_item(access_item(KIND_WRITE, CONF_ADDR + GPIO_SPAN, 32'h0000_000f));
        send_item(access_item(KIND_WRITE, INOUT_ADDR + GPIO_SPAN, 32'h0000_0003));
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS)
            send_item(pick_item());
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (BURST_ITEMS)
            send_item(pick_item());
        no_idle = 1'b0;
    endtask

    // result side: draw a stall after every result taken
    always @(negedge clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.read_data  = m_axis_tdata[31:0];
            got.irq        = m_axis_tdata[32];
            got.gpio_drive = m_axis_tdata[36:33];
            rx_stall       = no_idle ? 0 : $urandom_range(0, 3);
            if (awaited_resp.size() == 0) begin
                $error("unexpected result: read_data %h irq %b gpio_drive %h",
                       got.read_data, got.irq, got.gpio_drive);
                fail_count++;
            end else begin
                want = awaited_resp.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
                    fail_count++;
                end
                if (got.irq !== want.irq) begin
                    $error("irq: expected %b, actual %b", want.irq, got.irq);
                    fail_count++;
                end
                if (got.gpio_drive !== want.gpio_drive) begin
                    $error("gpio_drive: expected %h, actual %h",
                           want.gpio_drive, got.gpio_drive);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: count cycles with no handshake on either side
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", awaited_resp.size());
                $display("tb_display_ctrl_register_block_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        fail_count    = 0;
        rx_stall      = 0;
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        clear_shadow();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_head_config();
        test_vsync_irq();
        test_gpio();
        test_random_mix();
        test_back_to_back();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_resp.size() != 0)
            @(posedge clk);
        repeat (END_PAUSE) @(posedge clk);

        if (fail_count == 0)
            $display("tb_display_ctrl_register_block_core: PASS");
        else
            $display("tb_display_ctrl_register_block_core: FAIL");
        $finish;
    end

endmodule

/* display_ctrl_register_block_core.f */
+incdir+src
src/dcrb_pkg.sv
src/dcrb_mem.sv
src/dcrb_exec.sv
src/display_ctrl_register_block_core.sv
tb/tb_display_ctrl_register_block_core.sv
